### rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// shared types and constants of the response frame deframer
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam logic [7:0]  MARK_START    = 8'h21;
    localparam logic [7:0]  MARK_END      = 8'h0D;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_START = 2'd1;
    localparam logic [1:0] ERR_BAD_END   = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT   = 2'd3;

    // input item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] data_byte;
        logic [7:0] frame_zone;
        logic [7:0] frame_command;
        logic [7:0] frame_answer;
        logic [7:0] frame_length;
        logic [1:0] error_code;
    } rfd_result_t;

endpackage

### rtl/rfd_core.sv
// ----------------------------------------------------------------------------
// rfd_core
// frame phase machine: one registered item in, at most one result out
// ----------------------------------------------------------------------------
module rfd_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 take,
    input  logic                 in_cmd,
    input  logic [7:0]           in_byte,
    output logic                 res_valid,
    output rfd_pkg::rfd_result_t res,
    output logic                 hunting
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ZONE,
        PH_COMMAND,
        PH_ANSWER,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_END
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  zone_reg,    zone_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  answer_reg,  answer_next;
    logic [7:0]  length_reg,  length_next;
    logic [7:0]  left_reg,    left_next;
    logic [15:0] idle_reg,    idle_next;
    logic [15:0] timeout_reg;

    logic [15:0] idle_inc;
    logic [7:0]  left_dec;
    logic [1:0]  kind;
    logic [1:0]  err;

    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        zone_next    = zone_reg;
        command_next = command_reg;
        answer_next  = answer_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        idle_next    = idle_reg;
        res_valid    = 1'b0;
        kind         = rfd_pkg::KIND_PAYLOAD;
        err          = rfd_pkg::ERR_NONE;

        if (take)
        begin
            if (in_cmd == rfd_pkg::CMD_TICK)
            begin
                if (phase_reg != PH_HUNT)
                begin
                    if (idle_inc >= timeout_reg)
                    begin
                        phase_next = PH_HUNT;
                        idle_next  = 16'd0;
                        left_next  = 8'd0;
                        res_valid  = 1'b1;
                        kind       = rfd_pkg::KIND_ERROR;
                        err        = rfd_pkg::ERR_TIMEOUT;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            else
            begin
                idle_next = 16'd0;
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (in_byte != rfd_pkg::MARK_START)
                        begin
                            res_valid = 1'b1;
                            kind      = rfd_pkg::KIND_ERROR;
                            err       = rfd_pkg::ERR_BAD_START;
                        end
                        else
                        begin
                            zone_next    = 8'd0;
                            command_next = 8'd0;
                            answer_next  = 8'd0;
                            length_next  = 8'd0;
                            left_next    = 8'd0;
                            phase_next   = PH_ZONE;
                        end
                    end
                    PH_ZONE:
                    begin
                        zone_next  = in_byte;
                        phase_next = PH_COMMAND;
                    end
                    PH_COMMAND:
                    begin
                        command_next = in_byte;
                        phase_next   = PH_ANSWER;
                    end
                    PH_ANSWER:
                    begin
                        answer_next = in_byte;
                        phase_next  = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        length_next = in_byte;
                        left_next   = in_byte;
                        phase_next  = (in_byte == 8'd0) ? PH_END : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            phase_next = PH_END;
                        end
                        res_valid = 1'b1;
                        kind      = rfd_pkg::KIND_PAYLOAD;
                    end
                    PH_END:
                    begin
                        phase_next = PH_HUNT;
                        res_valid  = 1'b1;
                        if (in_byte != rfd_pkg::MARK_END)
                        begin
                            kind = rfd_pkg::KIND_ERROR;
                            err  = rfd_pkg::ERR_BAD_END;
                        end
                        else
                        begin
                            kind = rfd_pkg::KIND_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // header fields show the registers as they stand before this item
    always_comb
    begin
        res.result_kind   = kind;
        res.data_byte     = (kind == rfd_pkg::KIND_PAYLOAD) ? in_byte : 8'd0;
        res.frame_zone    = zone_reg;
        res.frame_command = command_reg;
        res.frame_answer  = answer_reg;
        res.frame_length  = length_reg;
        res.error_code    = err;
    end

    assign hunting = (phase_reg == PH_HUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            zone_reg    <= 8'd0;
            command_reg <= 8'd0;
            answer_reg  <= 8'd0;
            length_reg  <= 8'd0;
            left_reg    <= 8'd0;
            idle_reg    <= 16'd0;
            timeout_reg <= rfd_pkg::TIMEOUT_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            zone_reg    <= zone_next;
            command_reg <= command_next;
            answer_reg  <= answer_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            idle_reg    <= idle_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

endmodule

### rtl/rfd_out_skid.sv
// ----------------------------------------------------------------------------
// rfd_out_skid
// result register with one skid entry, full flag comes from a register
// ----------------------------------------------------------------------------
module rfd_out_skid
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rfd_pkg::rfd_result_t push_data,
    input  logic                 pop_ready,
    output logic                 out_valid,
    output rfd_pkg::rfd_result_t out_data,
    output logic                 full
);

    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    rfd_pkg::rfd_result_t out_data_reg;
    rfd_pkg::rfd_result_t skid_data_reg;
    logic                 out_free;

    // push only arrives while the skid entry is empty
    assign out_free = !out_valid_reg || pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

### rtl/response_frame_deframer.sv
// ----------------------------------------------------------------------------
// response_frame_deframer
// hunts for framed responses in a byte/tick stream and reports payload,
// frame completion and framing errors
// ----------------------------------------------------------------------------
//
//  channel   dir  payload
//  s_axis    in   tdata: byte_value; tuser: cmd (0 byte, 1 tick)
//  m_axis    out  tdata: data, header fields, error code; tuser: result kind
//  cfg       in   timeout_ticks, written whenever cfg_wr_en is high
//
//  one item is taken per cycle while s_axis_tready is high; each result
//  passes the input register, then the phase machine into the result register
//  rst_n clears the phase machine, header fields, counters and the
//  timeout register (3000); no clearing pass is needed
//  s_axis_tready is low only when the input register is full and the
//  result skid entry is occupied, so a stall on m_axis backs up in steps
//
module response_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,      // timeout_ticks

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] byte_value
    input  logic        s_axis_tuser,     // [0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,     // [7:0] data_byte, [15:8] frame_zone,
                                          // [23:16] frame_command,
                                          // [31:24] frame_answer,
                                          // [39:32] frame_length,
                                          // [41:40] error_code, rest zero
    output logic [1:0]  m_axis_tuser      // [1:0] result_kind
);

    // input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // core and result stage
    logic                 core_take;
    logic                 core_res_valid;
    rfd_pkg::rfd_result_t core_res;
    logic                 core_hunting;
    logic                 skid_full;
    rfd_pkg::rfd_result_t out_res;

    // the core consumes the held beat whenever the skid entry is free
    assign core_take     = in_valid_reg && !skid_full;
    assign s_axis_tready = !in_valid_reg || !skid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (core_take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    rfd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (core_take),
        .in_cmd      (in_cmd_reg),
        .in_byte     (in_byte_reg),
        .res_valid   (core_res_valid),
        .res         (core_res),
        .hunting     (core_hunting)
    );

    rfd_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_res_valid),
        .push_data (core_res),
        .pop_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .full      (skid_full)
    );

    // pack result beat, lowest field first
    assign m_axis_tdata = {6'd0, out_res.error_code, out_res.frame_length,
                           out_res.frame_answer, out_res.frame_command,
                           out_res.frame_zone, out_res.data_byte};
    assign m_axis_tuser = out_res.result_kind;

`ifndef SYNTHESIS
    // any error or frame-complete result sends the machine back to hunting
    a_err_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid && (core_res.result_kind == rfd_pkg::KIND_ERROR ||
                           core_res.result_kind == rfd_pkg::KIND_DONE)
        |=> core_hunting)
        else $error("result did not return phase machine to hunting");

    // payload beats only come out of a started frame
    a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid && core_res.result_kind == rfd_pkg::KIND_PAYLOAD
        |-> !core_hunting)
        else $error("payload result while hunting");

    // a held input beat is not dropped while the core cannot take it
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !core_take |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input beat lost while stalled");

    // the core never pushes a result into a full skid stage
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid |-> !skid_full)
        else $error("result pushed into full output stage");
`endif

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for response_frame_deframer: drives byte and tick beats
// with random idling, predicts every result beat with a local phase machine and
// checks each result beat field by field, in order
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT   = 5000;  // cycles with no beat on either side
    localparam int unsigned SETTLE_CYCLES = 6;     // extra wait once every result beat is seen

    // local phase machine states of the predictor
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ZONE,
        PH_COMMAND,
        PH_ANSWER,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_END
    } frame_phase_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] byte_value
    logic        s_axis_tuser;     // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;     // [7:0] data_byte, [15:8] frame_zone,
                                   // [23:16] frame_command, [31:24] frame_answer,
                                   // [39:32] frame_length, [41:40] error_code
    logic [1:0]  m_axis_tuser;     // [1:0] result_kind

    // predictor state, a copy of what the block should hold
    frame_phase_t frame_phase;
    logic [15:0]  timeout_reg;
    logic [15:0]  idle_ticks;
    logic [7:0]   zone_q;
    logic [7:0]   command_q;
    logic [7:0]   answer_q;
    logic [7:0]   length_q;
    logic [7:0]   bytes_left;

    rfd_pkg::rfd_result_t awaited_results[$];   // results predicted but not yet seen
    rfd_pkg::rfd_result_t oldest_result;
    int unsigned  useful_items;         // beats that are not ignored ticks
    int unsigned  mismatch_count;
    int unsigned  quiet_cycles;
    int unsigned  rx_hold_cycles;       // long output stall, counted down below
    bit           steady_flow;          // no idling on either side

    response_frame_deframer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor: one accepted beat in, zero or one result pushed
    // ------------------------------------------------------------------------
    function automatic void deframe_item(input logic cmd, input logic [7:0] value);
        rfd_pkg::rfd_result_t r;
        bit                   emit;
        r    = '0;
        emit = 1'b0;
        // ticks while hunting leave no trace at all
        if (cmd == rfd_pkg::CMD_TICK && frame_phase == PH_HUNT)
            return;
        useful_items++;
        if (cmd == rfd_pkg::CMD_TICK)
        begin
            // saturating tick count inside a frame
            if (idle_ticks != 16'hFFFF)
                idle_ticks++;
            if (idle_ticks >= timeout_reg)
            begin
                frame_phase   = PH_HUNT;
                idle_ticks    = '0;
                bytes_left    = '0;
                emit          = 1'b1;
                r.result_kind = rfd_pkg::KIND_ERROR;
                r.error_code  = rfd_pkg::ERR_TIMEOUT;
            end
        end
        else
        begin
            // any byte restarts the timeout count
            idle_ticks = '0;
            case (frame_phase)
                PH_HUNT:
                begin
                    if (value != rfd_pkg::MARK_START)
                    begin
                        // header fields keep the last frame's values
                        emit          = 1'b1;
                        r.result_kind = rfd_pkg::KIND_ERROR;
                        r.error_code  = rfd_pkg::ERR_BAD_START;
                    end
                    else
                    begin
                        zone_q      = '0;
                        command_q   = '0;
                        answer_q    = '0;
                        length_q    = '0;
                        bytes_left  = '0;
                        frame_phase = PH_ZONE;
                    end
                end
                PH_ZONE:
                begin
                    zone_q      = value;
                    frame_phase = PH_COMMAND;
                end
                PH_COMMAND:
                begin
                    command_q   = value;
                    frame_phase = PH_ANSWER;
                end
                PH_ANSWER:
                begin
                    answer_q    = value;
                    frame_phase = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    // zero length goes straight to the end byte
                    length_q    = value;
                    bytes_left  = value;
                    frame_phase = (value == 8'd0) ? PH_END : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    bytes_left--;
                    if (bytes_left == 8'd0)
                        frame_phase = PH_END;
                    emit          = 1'b1;
                    r.result_kind = rfd_pkg::KIND_PAYLOAD;
                    r.data_byte   = value;
                end
                default:
                begin
                    frame_phase   = PH_HUNT;
                    emit          = 1'b1;
                    r.result_kind = (value == rfd_pkg::MARK_END) ? rfd_pkg::KIND_DONE
                                                                 : rfd_pkg::KIND_ERROR;
                    r.error_code  = (value == rfd_pkg::MARK_END) ? rfd_pkg::ERR_NONE
                                                                 : rfd_pkg::ERR_BAD_END;
                end
            endcase
        end
        if (emit)
        begin
            r.frame_zone    = zone_q;
            r.frame_command = command_q;
            r.frame_answer  = answer_q;
            r.frame_length  = length_q;
            awaited_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: result beat mismatch on %s, expected 'h%0h, got 'h%0h",
                 $time, field, want, got);
        mismatch_count++;
    endtask

    // sampled at the edge, so values are those just before it
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("unexpected beat (kind)", 0, m_axis_tuser);
            else
            begin
                oldest_result = awaited_results.pop_front();
                if (m_axis_tuser != oldest_result.result_kind)
                    report_mismatch("result_kind", oldest_result.result_kind,
                                    m_axis_tuser);
                if (m_axis_tdata[7:0] != oldest_result.data_byte)
                    report_mismatch("data_byte", oldest_result.data_byte,
                                    m_axis_tdata[7:0]);
                if (m_axis_tdata[15:8] != oldest_result.frame_zone)
                    report_mismatch("frame_zone", oldest_result.frame_zone,
                                    m_axis_tdata[15:8]);
                if (m_axis_tdata[23:16] != oldest_result.frame_command)
                    report_mismatch("frame_command", oldest_result.frame_command,
                                    m_axis_tdata[23:16]);
                if (m_axis_tdata[31:24] != oldest_result.frame_answer)
                    report_mismatch("frame_answer", oldest_result.frame_answer,
                                    m_axis_tdata[31:24]);
                if (m_axis_tdata[39:32] != oldest_result.frame_length)
                    report_mismatch("frame_length", oldest_result.frame_length,
                                    m_axis_tdata[39:32]);
                if (m_axis_tdata[41:40] != oldest_result.error_code)
                    report_mismatch("error_code", oldest_result.error_code,
                                    m_axis_tdata[41:40]);
            end
        end
    end

    // watchdog: too long without a beat on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, awaited_results.size());
            $display("[response_frame_deframer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stall bursts, or a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles != 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (!steady_flow && $urandom_range(0, 4) == 0)
            begin
                // random stall burst
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one beat, return at the edge that takes it; valid stays high so
    // back to back beats need no extra assignment in the same step
    task automatic send_item(input logic cmd, input logic [7:0] value);
        if (!steady_flow && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        deframe_item(cmd, value);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_item(rfd_pkg::CMD_TICK, 8'($urandom));
    endtask

    // stop offering, wait for every predicted result, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle, right after drain_results
    task automatic write_timeout(input logic [15:0] ticks);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        timeout_reg  = ticks;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // hunting ticks, bad starts, zero length, full range payload, bad end,
    // a start byte inside the payload, a short tick gap inside a frame
    task automatic test_directed();
        logic [7:0] stream[$];
        send_item(rfd_pkg::CMD_TICK, 8'hFF);
        stream = '{8'h00, 8'hFF, 8'h0D,
                   rfd_pkg::MARK_START, 8'hFF, 8'h00, 8'hA5, 8'h00,
                   rfd_pkg::MARK_END,
                   8'h20,
                   rfd_pkg::MARK_START, 8'h01, 8'h02, 8'h03, 8'h02, 8'h00, 8'hFF,
                   rfd_pkg::MARK_END,
                   rfd_pkg::MARK_START, 8'h80, 8'h7F, 8'h55, 8'h01,
                   rfd_pkg::MARK_START, 8'h0C};
        foreach (stream[i])
        begin
            if (i == 14)
                send_ticks(2);
            send_item(rfd_pkg::CMD_BYTE, stream[i]);
        end
        drain_results();
    endtask

    // tick gaps well below the reset value do not time out, a byte restarts
    // the count
    task automatic test_default_timeout();
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_START);
        send_ticks(40);
        send_item(rfd_pkg::CMD_BYTE, 8'h05);
        send_ticks(40);
        send_item(rfd_pkg::CMD_BYTE, 8'h06);
        send_item(rfd_pkg::CMD_BYTE, 8'h07);
        send_item(rfd_pkg::CMD_BYTE, 8'h00);
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_END);
        drain_results();
    endtask

    task automatic test_timeout_settings();
        // zero: the first tick inside a frame times out
        write_timeout(16'd0);
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_START);
        send_ticks(2);
        drain_results();
        // timeout during the header reports what came so far
        write_timeout(16'd1);
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_START);
        send_item(rfd_pkg::CMD_BYTE, 8'h11);
        send_ticks(1);
        drain_results();
        write_timeout(16'd2);
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_START);
        send_item(rfd_pkg::CMD_BYTE, 8'hAA);
        send_item(rfd_pkg::CMD_BYTE, 8'hBB);
        send_ticks(1);
        send_item(rfd_pkg::CMD_BYTE, 8'hCC);
        send_ticks(2);
        drain_results();
        // largest setting: a tick gap inside a frame stays far below it
        write_timeout(16'hFFFF);
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_START);
        send_item(rfd_pkg::CMD_BYTE, 8'h01);
        send_item(rfd_pkg::CMD_BYTE, 8'h02);
        send_item(rfd_pkg::CMD_BYTE, 8'h03);
        send_item(rfd_pkg::CMD_BYTE, 8'h01);
        send_ticks(10);
        send_item(rfd_pkg::CMD_BYTE, 8'h44);
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_END);
        drain_results();
    endtask

    // result side held off while a long frame keeps coming in
    task automatic test_output_stall();
        rx_hold_cycles = 300;
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_START);
        send_item(rfd_pkg::CMD_BYTE, 8'h5A);
        send_item(rfd_pkg::CMD_BYTE, 8'hC3);
        send_item(rfd_pkg::CMD_BYTE, 8'h3C);
        send_item(rfd_pkg::CMD_BYTE, 8'hFF);
        repeat (255) send_item(rfd_pkg::CMD_BYTE, 8'($urandom));
        send_item(rfd_pkg::CMD_BYTE, rfd_pkg::MARK_END);
        drain_results();
    endtask

    // mostly well formed frames with random content, some broken or
    // truncated, mixed with noise and tick gaps
    task automatic test_random_traffic(input logic [15:0] ticks,
                                       input int unsigned item_target);
        logic [7:0]  frame_bytes[$];
        int unsigned stop_at;
        int unsigned len;
        int unsigned cut;
        write_timeout(ticks);
        stop_at = useful_items + item_target;
        while (useful_items < stop_at)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                repeat ($urandom_range(1, 4))
                    send_item($urandom_range(0, 1) ? rfd_pkg::CMD_TICK
                                                   : rfd_pkg::CMD_BYTE,
                              8'($urandom));
            end
            else
            begin
                frame_bytes = {};
                frame_bytes.push_back(rfd_pkg::MARK_START);
                repeat (3) frame_bytes.push_back(8'($urandom));
                // mostly short payloads, now and then up to the maximum
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 6);
                frame_bytes.push_back(8'(len));
                repeat (len) frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                                  : rfd_pkg::MARK_END);
                if ($urandom_range(0, 9) == 0)
                begin
                    cut = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > cut)
                        void'(frame_bytes.pop_back());
                end
                foreach (frame_bytes[i])
                begin
                    // tick gaps, sometimes long enough to time out
                    if ($urandom_range(0, 4) == 0)
                    begin
                        if (timeout_reg <= 16'd64 && $urandom_range(0, 19) == 0)
                            send_ticks(timeout_reg);
                        else
                            send_ticks($urandom_range(1, 3));
                    end
                    send_item(rfd_pkg::CMD_BYTE, frame_bytes[i]);
                end
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = rfd_pkg::CMD_BYTE;
        steady_flow    = 1'b0;
        rx_hold_cycles = 0;
        useful_items   = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        // predictor reset state
        frame_phase = PH_HUNT;
        timeout_reg = rfd_pkg::TIMEOUT_RESET;
        idle_ticks  = '0;
        zone_q      = '0;
        command_q   = '0;
        answer_q    = '0;
        length_q    = '0;
        bytes_left  = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_default_timeout();
        test_timeout_settings();
        test_random_traffic(16'd5, 350);
        test_random_traffic(16'd1, 150);
        test_random_traffic(rfd_pkg::TIMEOUT_RESET, 350);
        test_output_stall();
        test_random_traffic(16'hFFFF, 350);
        // last stretch runs without idling
        steady_flow = 1'b1;
        test_random_traffic(16'd24, 350);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("[response_frame_deframer] OK");
        else
            $display("[response_frame_deframer] ERROR");
        $finish;
    end

endmodule
